@@ rtl/pvrd_pkg.sv @@
// pvrd_pkg: shared widths, constants, register indexes and types of the voltage regulator
`timescale 1ns / 1ps
`default_nettype none

package pvrd_pkg;

  // error history window
  localparam int ERROR_WINDOW = 10;
  localparam int PTR_W = (ERROR_WINDOW > 1) ? $clog2(ERROR_WINDOW) : 1;

  // field widths
  localparam int SP_W     = 16;
  localparam int RAIL_W   = 15;
  localparam int ERR_W    = 17;
  localparam int GAIN_W   = 24;
  localparam int MARGIN_W = 12;
  localparam int PULSE_W  = 10;
  localparam int THR_W    = 10;
  localparam int CMP_W    = 14;
  localparam int MEAN_W   = 17;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_USER_LIMIT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ERR_MARGIN  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_OVERVOLTAGE = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PULSE_MAX   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_THR  = 3'd6;

  // register defaults
  localparam logic [GAIN_W-1:0]   PROP_GAIN_RST   = 24'd83886;
  localparam logic [GAIN_W-1:0]   INTEG_GAIN_RST  = 24'd3355;
  localparam logic [SP_W-1:0]     USER_LIMIT_RST  = 16'd38300;
  localparam logic [MARGIN_W-1:0] ERR_MARGIN_RST  = 12'd250;
  localparam logic [SP_W-1:0]     OVERVOLTAGE_RST = 16'd40000;
  localparam logic [PULSE_W-1:0]  PULSE_MAX_RST   = 10'd700;
  localparam logic [THR_W-1:0]    SETTLE_THR_RST  = 10'd10;

  // setpoint after reset
  localparam logic [SP_W-1:0] SETPOINT_RST = 16'd15000;

  // integral accumulator
  localparam int INTEG_W = 40;
  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  // split of the integral for the gain multiply
  localparam int LO_W    = 20;
  localparam int HI_W    = INTEG_W - LO_W;
  localparam int PPLO_W  = LO_W + GAIN_W;
  localparam int PPHI_W  = HI_W + GAIN_W + 1;
  localparam int PTERM_W = ERR_W + GAIN_W + 1;

  // integral term and its clamp
  localparam int ITERM_FULL_W = PPHI_W + LO_W;
  localparam int TERM_SHIFT   = 50;
  localparam int ITERM_W      = TERM_SHIFT + 2;
  localparam logic signed [ITERM_FULL_W-1:0] TERM_HI = $signed(ITERM_FULL_W'(1) << TERM_SHIFT);
  localparam logic signed [ITERM_FULL_W-1:0] TERM_LO = -TERM_HI;

  // pulse in Q.24
  localparam int FRAC_W = 24;
  localparam int PMAX_W = PULSE_W + FRAC_W;
  localparam int PSUM_W = ITERM_W + 1;

  // running error sum and division by the window length
  localparam int WSUM_W      = ERR_W + $clog2(ERROR_WINDOW);
  localparam int RECIP_SHIFT = WSUM_W + 3;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / ERROR_WINDOW);
  localparam int PROD_W      = WSUM_W + RECIP_W;

  // configuration registers
  typedef struct packed {
    logic [GAIN_W-1:0]   prop_gain;
    logic [GAIN_W-1:0]   integ_gain;
    logic [SP_W-1:0]     user_limit;
    logic [MARGIN_W-1:0] error_margin;
    logic [SP_W-1:0]     overvoltage;
    logic [PULSE_W-1:0]  pulse_max;
    logic [THR_W-1:0]    settle_thr;
  } cfg_t;

  // per-stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_en_t;

endpackage

`default_nettype wire

@@ rtl/pvrd_track.sv @@
// pvrd_track: setpoint override and clamp, error, saturating integral and error history
`timescale 1ns / 1ps
`default_nettype none

module pvrd_track import pvrd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  pipe_en_t                  en,
  input  cfg_t                      cfg,
  input  logic                      load_q,
  input  logic [SP_W-1:0]           sp_in_q,
  input  logic [SP_W-1:0]           vout_q,
  input  logic [RAIL_W-1:0]         rail_q,
  output logic signed [ERR_W-1:0]   err_s1,
  output logic [SP_W-1:0]           held_setpoint,
  output logic signed [INTEG_W-1:0] integral_sum,
  output logic signed [WSUM_W-1:0]  window_sum
);

  logic signed [ERR_W-1:0] error_ring [ERROR_WINDOW];
  logic [PTR_W-1:0]        ring_pointer;

  logic [SP_W-1:0]           sp_sel;
  logic [SP_W:0]             ov_lim;
  logic [SP_W:0]             sp_ov;
  logic [SP_W-1:0]           sp_cap;
  logic [SP_W-1:0]           rail_up;
  logic [SP_W-1:0]           sp_next;
  logic signed [ERR_W-1:0]   err_next;
  logic signed [INTEG_W:0]   integ_wide;
  logic signed [INTEG_W-1:0] integral_sum_next;
  logic signed [WSUM_W-1:0]  window_sum_next;
  logic [PTR_W-1:0]          ring_pointer_next;

  // setpoint: load, overvoltage override, cap at user limit, rail headroom
  always_comb begin
    sp_sel  = load_q ? sp_in_q : held_setpoint;
    ov_lim  = {1'b0, cfg.overvoltage} + (SP_W+1)'(cfg.error_margin);
    sp_ov   = ({1'b0, vout_q} > ov_lim) ?
              ({1'b0, cfg.user_limit} + (SP_W+1)'(cfg.error_margin)) : {1'b0, sp_sel};
    sp_cap  = (sp_ov > {1'b0, cfg.user_limit}) ? cfg.user_limit : sp_ov[SP_W-1:0];
    rail_up = SP_W'(rail_q) + SP_W'({cfg.error_margin, 1'b0});
    sp_next = (sp_cap < SP_W'(rail_q)) ? rail_up : sp_cap;
    err_next = $signed({1'b0, sp_next}) - $signed({1'b0, vout_q});
  end

  // integral with saturation at the 40-bit limits
  always_comb begin
    integ_wide = $signed({integral_sum[INTEG_W-1], integral_sum})
               + $signed((INTEG_W+1)'(err_next));
    if (integ_wide[INTEG_W] != integ_wide[INTEG_W-1]) begin
      integral_sum_next = integ_wide[INTEG_W] ? INTEG_MIN : INTEG_MAX;
    end else begin
      integral_sum_next = integ_wide[INTEG_W-1:0];
    end
  end

  // running window sum: drop the oldest error, add the new one
  always_comb begin
    window_sum_next = window_sum - WSUM_W'(error_ring[ring_pointer]) + WSUM_W'(err_next);
    ring_pointer_next = (ring_pointer == PTR_W'(ERROR_WINDOW - 1)) ?
                        '0 : ring_pointer + PTR_W'(1);
  end

  // state update once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      held_setpoint <= SETPOINT_RST;
      integral_sum  <= '0;
      window_sum    <= '0;
      ring_pointer  <= '0;
      for (int i = 0; i < ERROR_WINDOW; i++) begin
        error_ring[i] <= '0;
      end
    end else if (en.s1) begin
      held_setpoint            <= sp_next;
      integral_sum             <= integral_sum_next;
      window_sum               <= window_sum_next;
      ring_pointer             <= ring_pointer_next;
      error_ring[ring_pointer] <= err_next;
    end
  end

  // error for the later stages
  always_ff @(posedge clk) begin
    if (en.s1) begin
      err_s1 <= err_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pvrd_pulse.sv @@
// pvrd_pulse: gain multiplies, integral term clamp, pulse clamp and dithered compare value
`timescale 1ns / 1ps
`default_nettype none

module pvrd_pulse import pvrd_pkg::*; (
  input  logic                      clk,
  input  pipe_en_t                  en,
  input  cfg_t                      cfg,
  input  logic signed [ERR_W-1:0]   err_s1,
  input  logic signed [INTEG_W-1:0] integral_sum,
  output logic [CMP_W-1:0]          compare_value
);

  logic signed [PTERM_W-1:0] pterm_s2;
  logic [PPLO_W-1:0]         pplo_s2;
  logic signed [PPHI_W-1:0]  pphi_s2;
  logic signed [PTERM_W-1:0] pterm_s3;
  logic signed [ITERM_W-1:0] iterm_s3;
  logic [PMAX_W-1:0]         pulse_s4;

  logic signed [ITERM_FULL_W-1:0] iterm_full;
  logic signed [ITERM_FULL_W-1:0] iterm_clamp;
  logic signed [PSUM_W-1:0]       psum;
  logic [PSUM_W-1:0]              pmax_ext;
  logic [PMAX_W-1:0]              pulse_next;
  logic [FRAC_W+3:0]              dither_prod;
  logic [CMP_W-1:0]               compare_next;

  // stage 2: proportional product and two partial products of the integral term
  always_ff @(posedge clk) begin
    if (en.s2) begin
      pterm_s2 <= PTERM_W'(err_s1) * PTERM_W'($signed({1'b0, cfg.prop_gain}));
      pplo_s2  <= PPLO_W'(integral_sum[LO_W-1:0]) * PPLO_W'(cfg.integ_gain);
      pphi_s2  <= PPHI_W'($signed(integral_sum[INTEG_W-1:LO_W]))
                * PPHI_W'($signed({1'b0, cfg.integ_gain}));
    end
  end

  // stage 3: recombine the integral term and clamp it
  always_comb begin
    iterm_full = $signed({pphi_s2, {LO_W{1'b0}}})
               + $signed({{(ITERM_FULL_W-PPLO_W){1'b0}}, pplo_s2});
    if (iterm_full > TERM_HI) begin
      iterm_clamp = TERM_HI;
    end else if (iterm_full < TERM_LO) begin
      iterm_clamp = TERM_LO;
    end else begin
      iterm_clamp = iterm_full;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      pterm_s3 <= pterm_s2;
      iterm_s3 <= ITERM_W'(iterm_clamp);
    end
  end

  // stage 4: pulse sum, clamp to 0..pulse_max
  always_comb begin
    psum     = PSUM_W'(pterm_s3) + PSUM_W'(iterm_s3);
    pmax_ext = PSUM_W'({cfg.pulse_max, {FRAC_W{1'b0}}});
    if (psum[PSUM_W-1]) begin
      pulse_next = '0;
    end else if ($unsigned(psum) > pmax_ext) begin
      pulse_next = pmax_ext[PMAX_W-1:0];
    end else begin
      pulse_next = psum[PMAX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      pulse_s4 <= pulse_next;
    end
  end

  // stage 5: integer part shifted up plus floor(15 * fraction)
  always_comb begin
    dither_prod  = {pulse_s4[FRAC_W-1:0], 4'b0000} - {4'b0000, pulse_s4[FRAC_W-1:0]};
    compare_next = {pulse_s4[PMAX_W-1:FRAC_W], 4'b0000}
                 + CMP_W'(dither_prod[FRAC_W+3:FRAC_W]);
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      compare_value <= compare_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pvrd_mean.sv @@
// pvrd_mean: mean of the error window by reciprocal multiply, and the settled flag
`timescale 1ns / 1ps
`default_nettype none

module pvrd_mean import pvrd_pkg::*; (
  input  logic                     clk,
  input  pipe_en_t                 en,
  input  cfg_t                     cfg,
  input  logic signed [WSUM_W-1:0] window_sum,
  output logic signed [MEAN_W-1:0] mean_error_mv,
  output logic                     settled
);

  logic [PROD_W-1:0]        prod_s2;
  logic [WSUM_W-1:0]        abs_s2;
  logic                     neg_s2;
  logic [MEAN_W-1:0]        mag_s3;
  logic                     neg_s3;
  logic signed [MEAN_W-1:0] mean_s4;
  logic                     settled_s4;

  logic [WSUM_W-1:0] abs_val;
  logic [WSUM_W-1:0] quot0;
  logic [WSUM_W-1:0] quot_times;
  logic [WSUM_W-1:0] rem;
  logic [WSUM_W-1:0] quot;

  // stage 2: magnitude times the reciprocal of the window length
  assign abs_val = window_sum[WSUM_W-1] ? $unsigned(-window_sum) : $unsigned(window_sum);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      prod_s2 <= PROD_W'(abs_val) * PROD_W'(RECIP);
      abs_s2  <= abs_val;
      neg_s2  <= window_sum[WSUM_W-1];
    end
  end

  // stage 3: estimate is low by at most one, fix it with the remainder
  always_comb begin
    quot0      = prod_s2[RECIP_SHIFT +: WSUM_W];
    quot_times = WSUM_W'(quot0 * WSUM_W'(ERROR_WINDOW));
    rem        = abs_s2 - quot_times;
    quot       = (rem >= WSUM_W'(ERROR_WINDOW)) ? quot0 + WSUM_W'(1) : quot0;
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      mag_s3 <= MEAN_W'(quot);
      neg_s3 <= neg_s2;
    end
  end

  // stage 4: restore the sign, compare against the threshold
  always_ff @(posedge clk) begin
    if (en.s4) begin
      mean_s4    <= neg_s3 ? -$signed(mag_s3) : $signed(mag_s3);
      settled_s4 <= (mag_s3 < MEAN_W'(cfg.settle_thr));
    end
  end

  // stage 5: output register
  always_ff @(posedge clk) begin
    if (en.s5) begin
      mean_error_mv <= mean_s4;
      settled       <= settled_s4;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pi_voltage_regulator_dither_pwm.sv @@
// pi_voltage_regulator_dither_pwm: PI voltage regulator with clamped, dithered PWM compare
// Each result passes the input register and 5 stages. Throughput: one item per cycle
// unless the output stalls; setpoint, integral and error history close in one stage.
// Each stage advances when the next one is empty or moving, so bubbles fill under a stall.
// Reset: clears all stage valids, restores register defaults, setpoint 15000 mV,
// zero integral and zero error history.
`timescale 1ns / 1ps
`default_nettype none

module pi_voltage_regulator_dither_pwm import pvrd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     cfg_write_en,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     load_setpoint,
  input  logic [SP_W-1:0]          setpoint_mv,
  input  logic [SP_W-1:0]          output_mv,
  input  logic [RAIL_W-1:0]        rail_mv,
  // output channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [CMP_W-1:0]         compare_value,
  output logic signed [ERR_W-1:0]  error_mv,
  output logic [SP_W-1:0]          active_setpoint_mv,
  output logic signed [MEAN_W-1:0] mean_error_mv,
  output logic                     settled
);

  cfg_t     cfg;
  pipe_en_t en;
  logic     en_s0;
  logic [5:0] v;
  logic [5:0] rdy;

  logic              load_q;
  logic [SP_W-1:0]   sp_in_q;
  logic [SP_W-1:0]   vout_q;
  logic [RAIL_W-1:0] rail_q;

  logic signed [ERR_W-1:0]   err_s1;
  logic [SP_W-1:0]           held_setpoint;
  logic signed [INTEG_W-1:0] integral_sum;
  logic signed [WSUM_W-1:0]  window_sum;

  logic signed [ERR_W-1:0] err_s2, err_s3, err_s4;
  logic [SP_W-1:0]         sp_s2, sp_s3, sp_s4;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain    <= PROP_GAIN_RST;
      cfg.integ_gain   <= INTEG_GAIN_RST;
      cfg.user_limit   <= USER_LIMIT_RST;
      cfg.error_margin <= ERR_MARGIN_RST;
      cfg.overvoltage  <= OVERVOLTAGE_RST;
      cfg.pulse_max    <= PULSE_MAX_RST;
      cfg.settle_thr   <= SETTLE_THR_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_PROP_GAIN:   cfg.prop_gain    <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN:  cfg.integ_gain   <= cfg_data[GAIN_W-1:0];
        REG_USER_LIMIT:  cfg.user_limit   <= cfg_data[SP_W-1:0];
        REG_ERR_MARGIN:  cfg.error_margin <= cfg_data[MARGIN_W-1:0];
        REG_OVERVOLTAGE: cfg.overvoltage  <= cfg_data[SP_W-1:0];
        REG_PULSE_MAX:   cfg.pulse_max    <= cfg_data[PULSE_W-1:0];
        REG_SETTLE_THR:  cfg.settle_thr   <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // stage ready chain: a stage takes new data when empty or when it drains
  always_comb begin
    rdy[5] = !v[5] || !out_stall;
    for (int k = 4; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign en_s0     = in_valid && rdy[0];
  assign en.s1     = v[0] && rdy[1];
  assign en.s2     = v[1] && rdy[2];
  assign en.s3     = v[2] && rdy[3];
  assign en.s4     = v[3] && rdy[4];
  assign en.s5     = v[4] && rdy[5];
  assign in_stall  = !rdy[0];
  assign out_valid = v[5];

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < 6; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (en_s0) begin
      load_q  <= load_setpoint;
      sp_in_q <= setpoint_mv;
      vout_q  <= output_mv;
      rail_q  <= rail_mv;
    end
  end

  pvrd_track u_track (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .cfg           (cfg),
    .load_q        (load_q),
    .sp_in_q       (sp_in_q),
    .vout_q        (vout_q),
    .rail_q        (rail_q),
    .err_s1        (err_s1),
    .held_setpoint (held_setpoint),
    .integral_sum  (integral_sum),
    .window_sum    (window_sum)
  );

  pvrd_pulse u_pulse (
    .clk           (clk),
    .en            (en),
    .cfg           (cfg),
    .err_s1        (err_s1),
    .integral_sum  (integral_sum),
    .compare_value (compare_value)
  );

  pvrd_mean u_mean (
    .clk           (clk),
    .en            (en),
    .cfg           (cfg),
    .window_sum    (window_sum),
    .mean_error_mv (mean_error_mv),
    .settled       (settled)
  );

  // error and setpoint ride along to the output register
  always_ff @(posedge clk) begin
    if (en.s2) begin
      err_s2 <= err_s1;
      sp_s2  <= held_setpoint;
    end
    if (en.s3) begin
      err_s3 <= err_s2;
      sp_s3  <= sp_s2;
    end
    if (en.s4) begin
      err_s4 <= err_s3;
      sp_s4  <= sp_s3;
    end
    if (en.s5) begin
      error_mv           <= err_s4;
      active_setpoint_mv <= sp_s4;
    end
  end

`ifndef SYNTHESIS
  // dither never reaches fifteen
  a_dither_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (compare_value[3:0] != 4'hF))
    else $error("dither field out of range");

  // a full pipeline with a stalled output holds off the input
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    ((&v) && out_stall) |-> in_stall)
    else $error("input taken while pipeline full");

  // last stage moves into an empty output register
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (v[4] && !out_valid) |=> out_valid)
    else $error("result lost before output register");
`endif

endmodule

`default_nettype wire

@@ dv/pvrd_tick_checker.sv @@
// pvrd_tick_checker: predicts every regulator tick and checks the result transfers
`timescale 1ns / 1ps
`default_nettype none

module pvrd_tick_checker import pvrd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write_en,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     load_setpoint,
  input  logic [SP_W-1:0]          setpoint_mv,
  input  logic [SP_W-1:0]          output_mv,
  input  logic [RAIL_W-1:0]        rail_mv,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [CMP_W-1:0]         compare_value,
  input  logic signed [ERR_W-1:0]  error_mv,
  input  logic [SP_W-1:0]          active_setpoint_mv,
  input  logic signed [MEAN_W-1:0] mean_error_mv,
  input  logic                     settled,
  output int                       fail_count,
  output int                       outstanding,
  output int                       ticks_checked
);

  // integral saturation and integral term clamp
  localparam longint INTEG_TOP    = (longint'(1) <<< 39) - 1;
  localparam longint INTEG_BOTTOM = -INTEG_TOP - 1;
  localparam longint TERM_CAP     = longint'(1) <<< 50;

  typedef struct {
    logic [CMP_W-1:0]         compare;
    logic signed [ERR_W-1:0]  err;
    logic [SP_W-1:0]          setpoint;
    logic signed [MEAN_W-1:0] mean;
    logic                     settled;
  } tick_result_t;

  // shadow of the registers and the controller state
  cfg_t            regs;
  logic [SP_W-1:0] held_sp;
  longint          integ;
  longint          err_hist [ERROR_WINDOW];
  int              hist_ptr;
  tick_result_t    expected_ticks [$];

  // one control tick: setpoint override and clamp, PI step, dither, error mean
  function automatic tick_result_t predict_tick(input logic load, input logic [SP_W-1:0] sp_in,
                                                input logic [SP_W-1:0] vout,
                                                input logic [RAIL_W-1:0] rail);
    longint       sp, err, pterm, iterm, pulse, pmax, wsum, mean, absmean, ip, frac, cmp;
    tick_result_t r;
    if (load) held_sp = sp_in;
    sp = longint'(held_sp);
    if (longint'(vout) > longint'(regs.overvoltage) + longint'(regs.error_margin))
      sp = longint'(regs.user_limit) + longint'(regs.error_margin);
    if (sp > longint'(regs.user_limit)) sp = longint'(regs.user_limit);
    if (sp < longint'(rail)) sp = longint'(rail) + 2 * longint'(regs.error_margin);
    held_sp = sp[SP_W-1:0];
    err = longint'(held_sp) - longint'(vout);

    integ = integ + err;
    if (integ > INTEG_TOP) integ = INTEG_TOP;
    if (integ < INTEG_BOTTOM) integ = INTEG_BOTTOM;

    pterm = err * longint'(regs.prop_gain);
    iterm = integ * longint'(regs.integ_gain);
    if (iterm > TERM_CAP) iterm = TERM_CAP;
    if (iterm < -TERM_CAP) iterm = -TERM_CAP;
    pulse = pterm + iterm;
    pmax = longint'(regs.pulse_max) <<< 24;
    if (pulse > pmax) pulse = pmax;
    if (pulse < 0) pulse = 0;

    // integer part above four dither bits
    ip = pulse >>> 24;
    frac = pulse & 64'hFF_FFFF;
    cmp = (ip <<< 4) + ((15 * frac) >>> 24);

    // error history, mean truncated toward zero
    err_hist[hist_ptr] = err;
    hist_ptr = (hist_ptr + 1 >= ERROR_WINDOW) ? 0 : hist_ptr + 1;
    wsum = 0;
    for (int i = 0; i < ERROR_WINDOW; i++) wsum += err_hist[i];
    mean = wsum / longint'(ERROR_WINDOW);
    absmean = (mean < 0) ? -mean : mean;

    r.compare  = cmp[CMP_W-1:0];
    r.err      = err[ERR_W-1:0];
    r.setpoint = held_sp;
    r.mean     = mean[MEAN_W-1:0];
    r.settled  = absmean < longint'(regs.settle_thr);
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // follow register writes and both channels
  always @(posedge clk) begin
    tick_result_t want;
    if (rst) begin
      regs.prop_gain    = PROP_GAIN_RST;
      regs.integ_gain   = INTEG_GAIN_RST;
      regs.user_limit   = USER_LIMIT_RST;
      regs.error_margin = ERR_MARGIN_RST;
      regs.overvoltage  = OVERVOLTAGE_RST;
      regs.pulse_max    = PULSE_MAX_RST;
      regs.settle_thr   = SETTLE_THR_RST;
      held_sp = SETPOINT_RST;
      integ = 0;
      foreach (err_hist[i]) err_hist[i] = 0;
      hist_ptr = 0;
      expected_ticks.delete();
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          REG_PROP_GAIN:   regs.prop_gain    = cfg_data[GAIN_W-1:0];
          REG_INTEG_GAIN:  regs.integ_gain   = cfg_data[GAIN_W-1:0];
          REG_USER_LIMIT:  regs.user_limit   = cfg_data[SP_W-1:0];
          REG_ERR_MARGIN:  regs.error_margin = cfg_data[MARGIN_W-1:0];
          REG_OVERVOLTAGE: regs.overvoltage  = cfg_data[SP_W-1:0];
          REG_PULSE_MAX:   regs.pulse_max    = cfg_data[PULSE_W-1:0];
          REG_SETTLE_THR:  regs.settle_thr   = cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_ticks.push_back(predict_tick(load_setpoint, setpoint_mv, output_mv, rail_mv));
      if (out_valid && !out_stall) begin
        if (expected_ticks.size() == 0) begin
          $error("result transfer with no tick outstanding");
          fail_count++;
        end else begin
          want = expected_ticks.pop_front();
          check_field("compare_value", want.compare, compare_value);
          check_field("error_mv", want.err, error_mv);
          check_field("active_setpoint_mv", want.setpoint, active_setpoint_mv);
          check_field("mean_error_mv", want.mean, mean_error_mv);
          check_field("settled", want.settled, settled);
          ticks_checked++;
        end
      end
    end
    outstanding <= expected_ticks.size();
  end

endmodule

`default_nettype wire

@@ dv/pi_voltage_regulator_dither_pwm_tb.sv @@
// pi_voltage_regulator_dither_pwm_tb: stimulus, register settings and verdict for the regulator
`timescale 1ns / 1ps
`default_nettype none

module pi_voltage_regulator_dither_pwm_tb;
  import pvrd_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int LONG_HOLD     = 64;
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_TICKS   = 130;
  localparam int WINDUP_TICKS  = 120;
  localparam int UNWIND_TICKS  = 180;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cfg_write_en;
  logic [CFG_INDEX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic                     load_setpoint;
  logic [SP_W-1:0]          setpoint_mv;
  logic [SP_W-1:0]          output_mv;
  logic [RAIL_W-1:0]        rail_mv;
  logic                     out_valid;
  logic                     out_stall;
  logic [CMP_W-1:0]         compare_value;
  logic signed [ERR_W-1:0]  error_mv;
  logic [SP_W-1:0]          active_setpoint_mv;
  logic signed [MEAN_W-1:0] mean_error_mv;
  logic                     settled;
  int                       fail_count;
  int                       outstanding;
  int                       ticks_checked;

  // stimulus bookkeeping
  cfg_t            settings;
  logic [SP_W-1:0] target_mv;
  bit              tx_idle_on;
  bit              rx_idle_on;
  bit              rx_hold_req;
  int              ticks_sent;
  int              settings_used;
  int              cycles;

  pi_voltage_regulator_dither_pwm u_top (.*);
  pvrd_tick_checker u_checker (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // offer one tick and hold it until the transfer
  task automatic drive_tick(input logic load, input logic [SP_W-1:0] sp,
                            input logic [SP_W-1:0] vout, input logic [RAIL_W-1:0] rail);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    load_setpoint <= load;
    setpoint_mv   <= sp;
    output_mv     <= vout;
    rail_mv       <= rail;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic end_phase();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_write_en <= 1'b1;
    cfg_index    <= index;
    cfg_data     <= data;
    @(posedge clk);
  endtask

  task automatic apply_settings(input cfg_t s);
    settings = s;
    write_reg(REG_PROP_GAIN, CFG_DATA_W'(s.prop_gain));
    write_reg(REG_INTEG_GAIN, CFG_DATA_W'(s.integ_gain));
    write_reg(REG_USER_LIMIT, CFG_DATA_W'(s.user_limit));
    write_reg(REG_ERR_MARGIN, CFG_DATA_W'(s.error_margin));
    write_reg(REG_OVERVOLTAGE, CFG_DATA_W'(s.overvoltage));
    write_reg(REG_PULSE_MAX, CFG_DATA_W'(s.pulse_max));
    write_reg(REG_SETTLE_THR, CFG_DATA_W'(s.settle_thr));
    cfg_write_en <= 1'b0;
    settings_used++;
  endtask

  // zero, full scale or random; gains are often scaled down into a useful range
  function automatic logic [23:0] draw_value(input int width, input bit scaled);
    logic [23:0] full, v;
    full = (24'd1 << width) - 24'd1;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = full;
      default: begin
        v = 24'($urandom) & full;
        if (scaled) v = v >> $urandom_range(0, 16);
      end
    endcase
    return v;
  endfunction

  function automatic cfg_t draw_settings();
    cfg_t s;
    s.prop_gain    = draw_value(GAIN_W, 1'b1);
    s.integ_gain   = draw_value(GAIN_W, 1'b1);
    s.user_limit   = SP_W'(draw_value(SP_W, 1'b0));
    s.error_margin = MARGIN_W'(draw_value(MARGIN_W, 1'b0));
    s.overvoltage  = SP_W'(draw_value(SP_W, 1'b0));
    s.pulse_max    = PULSE_W'(draw_value(PULSE_W, 1'b0));
    s.settle_thr   = THR_W'(draw_value(THR_W, 1'b0));
    return s;
  endfunction

  // mostly regulation around the setpoint, plus noise, overvoltage and rail cases
  task automatic random_tick();
    logic [SP_W-1:0]   sp, vout;
    logic [RAIL_W-1:0] rail;
    logic              load;
    int unsigned       pick;
    int                base, level;
    pick = $urandom_range(0, 9);
    sp   = SP_W'($urandom);
    vout = SP_W'($urandom);
    rail = RAIL_W'($urandom);
    load = 1'b0;
    if (pick < 5) begin
      if ($urandom_range(0, 7) == 0) begin
        load = 1'b1;
        target_mv = sp;
      end
      base = (target_mv > settings.user_limit) ? int'(settings.user_limit) : int'(target_mv);
      level = base + $urandom_range(0, 60) - 30;
      vout = (level < 0) ? '0 : (level > 65535) ? '1 : SP_W'(level);
      rail = RAIL_W'($urandom_range(0, base / 2));
    end else if (pick < 7) begin
      load = 1'($urandom_range(0, 1));
      if (load) target_mv = sp;
    end else if (pick == 7) begin
      // right at the overvoltage trip point, one side or the other
      level = int'(settings.overvoltage) + int'(settings.error_margin) + $urandom_range(0, 2);
      vout = (level > 65535) ? '1 : SP_W'(level);
      rail = RAIL_W'($urandom_range(0, 1000));
    end else begin
      // setpoint in the rail range, so it may fall below the rail
      load = 1'b1;
      sp = SP_W'($urandom_range(0, 32767));
      target_mv = sp;
    end
    drive_tick(load, sp, vout, rail);
  endtask

  // output side: random stall per result, one long hold-off on request
  initial begin
    int n;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (rx_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      n = rx_idle_on ? $urandom_range(0, 4) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    cfg_t s;
    rst           <= 1'b1;
    cfg_write_en  <= 1'b0;
    cfg_index     <= REG_PROP_GAIN;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    load_setpoint <= 1'b0;
    setpoint_mv   <= '0;
    output_mv     <= '0;
    rail_mv       <= '0;
    ticks_sent    = 0;
    settings_used = 0;
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    rx_hold_req   = 1'b0;
    settings.prop_gain    = PROP_GAIN_RST;
    settings.integ_gain   = INTEG_GAIN_RST;
    settings.user_limit   = USER_LIMIT_RST;
    settings.error_margin = ERR_MARGIN_RST;
    settings.overvoltage  = OVERVOLTAGE_RST;
    settings.pulse_max    = PULSE_MAX_RST;
    settings.settle_thr   = SETTLE_THR_RST;
    target_mv = SETPOINT_RST;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // defaults after reset: hold, cap, overvoltage boundary, rail headroom
    drive_tick(1'b0, 16'hFFFF, 16'd15000, 15'd0);
    drive_tick(1'b1, 16'd20000, 16'd19990, 15'd1000);
    drive_tick(1'b1, 16'hFFFF, 16'd0, 15'd0);
    drive_tick(1'b0, 16'd0, 16'd38300, 15'd0);
    drive_tick(1'b0, 16'd0, 16'd40250, 15'd0);
    drive_tick(1'b0, 16'd0, 16'd40251, 15'd0);
    drive_tick(1'b0, 16'd0, 16'hFFFF, 15'h7FFF);
    drive_tick(1'b1, 16'd10000, 16'd10000, 15'h7FFF);
    drive_tick(1'b1, 16'd30000, 16'd29000, 15'd30000);
    drive_tick(1'b1, 16'd29999, 16'd29000, 15'd30000);
    drive_tick(1'b1, 16'd38300, 16'd38300, 15'd0);
    drive_tick(1'b1, 16'd0, 16'd0, 15'd0);
    drive_tick(1'b0, 16'd0, 16'd0, 15'd1);
    end_phase();

    // every register at full scale: widest error both ways, highest rail lift
    apply_settings('1);
    drive_tick(1'b1, 16'hFFFF, 16'd0, 15'd0);
    drive_tick(1'b1, 16'd0, 16'hFFFF, 15'd0);
    drive_tick(1'b0, 16'd0, 16'd0, 15'h7FFF);
    drive_tick(1'b1, 16'd12345, 16'd12340, 15'd0);
    end_phase();

    // overvoltage register at zero, the rest at full scale; these outputs stay under the trip point
    s = '1;
    s.overvoltage = '0;
    apply_settings(s);
    drive_tick(1'b1, 16'd100, 16'd1, 15'd0);
    drive_tick(1'b0, 16'd0, 16'd0, 15'd0);
    end_phase();

    // every register at zero
    apply_settings('0);
    drive_tick(1'b1, 16'd500, 16'd400, 15'd0);
    drive_tick(1'b0, 16'd0, 16'd0, 15'd0);
    drive_tick(1'b0, 16'd0, 16'd0, 15'd100);
    end_phase();

    // integral windup with large positive errors, then unwind below zero
    s.prop_gain    = GAIN_W'($urandom_range(0, 4095));
    s.integ_gain   = GAIN_W'($urandom_range(0, 1023));
    s.user_limit   = '1;
    s.error_margin = MARGIN_W'($urandom);
    s.overvoltage  = '1;
    s.pulse_max    = '1;
    s.settle_thr   = THR_W'($urandom);
    apply_settings(s);
    repeat (WINDUP_TICKS)
      drive_tick(1'b1, 16'hFFFF, SP_W'($urandom_range(0, 255)), RAIL_W'($urandom_range(0, 255)));
    repeat (UNWIND_TICKS)
      drive_tick(1'b1, SP_W'($urandom_range(0, 255)), SP_W'($urandom_range(65280, 65535)),
                 15'd0);
    target_mv = '0;
    end_phase();

    // random phases, each under its own register setting
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: apply_settings('1);
        1: apply_settings('0);
        default: apply_settings(draw_settings());
      endcase
      tx_idle_on = $urandom_range(0, 3) != 0;
      rx_idle_on = $urandom_range(0, 3) != 0;
      if (p == 3) begin
        // back-to-back offers against a long output hold-off
        tx_idle_on  = 1'b0;
        rx_hold_req = 1'b1;
      end
      repeat (PHASE_TICKS) random_tick();
      end_phase();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d control ticks under %0d register settings, %0d results checked",
             ticks_sent, settings_used, ticks_checked);
    $display("including windup and unwind, overvoltage trips, rail lifts and a long hold-off");
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
